FILE: rtl/core/label_flow_checker_unit_assert.svh
// Assertion macros shared by the label flow checker modules.
`ifndef LABEL_FLOW_CHECKER_UNIT_ASSERT_SVH
`define LABEL_FLOW_CHECKER_UNIT_ASSERT_SVH
// Implication checked on every rising edge outside reset.
`define LFC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define LFC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/core/lfc_pkg.sv
// Shared types and codes of the label flow checker.
`timescale 1ns / 1ps
package lfc_pkg;
  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_FLOW   = 2'd2;
  localparam logic [1:0] REQ_SUBSET = 2'd3;
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FAIL    = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] SET_A  = 2'd0;
  localparam logic [1:0] SET_B  = 2'd1;
  localparam logic [1:0] SET_P1 = 2'd2;
  localparam logic [1:0] SET_P2 = 2'd3;
  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  set_select;
    logic [63:0] category;
  } lfc_req_t;
endpackage

FILE: rtl/core/lfc_front.sv
// Front end: accepts requests and holds them in a two-entry queue.
`timescale 1ns / 1ps
module lfc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lfc_pkg::lfc_req_t in_req,
  output logic              q_valid,
  input  logic              q_ready,
  output lfc_pkg::lfc_req_t q_req
);
  import lfc_pkg::*;
  lfc_req_t   mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  // Queue occupancy and pointers.
  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_req    = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end
  // Payload storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_req;
  end

  `include "label_flow_checker_unit_assert.svh"
  `LFC_ASSERT_IMP(a_no_over, cnt_r == 2'd2, !push || pop)
  `LFC_ASSERT_IMP(a_no_under, cnt_r == 2'd0, !pop)
  `LFC_ASSERT_NXT(a_cnt_step, push && !pop, cnt_r != 2'd0)
endmodule

FILE: rtl/core/lfc_back.sv
// Back end: set memory and the sequencer that runs each request.
`timescale 1ns / 1ps
module lfc_back #(
  parameter int LABEL_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [5:0]        secrecy_bit,
  input  logic              q_valid,
  output logic              q_ready,
  input  lfc_pkg::lfc_req_t q_req,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [1:0]        res_status,
  output logic [6:0]        res_count
);
  import lfc_pkg::*;
  localparam int IW = (LABEL_DEPTH > 1) ? $clog2(LABEL_DEPTH) : 1;
  localparam int CW = $clog2(LABEL_DEPTH + 1);
  localparam int AW = IW + 2;
  localparam logic [CW-1:0] DEPTH_C = CW'(LABEL_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_OUTER = 3'd1; // fetch outer entry
  localparam logic [2:0] S_OWAIT = 3'd2; // outer data arrives
  localparam logic [2:0] S_INNER = 3'd3; // scan one search set
  localparam logic [2:0] S_DONE  = 3'd4;

  // Each set owns a power-of-two slice so that {set, index} addresses it.
  logic [63:0]   mem [4*(1 << IW)];
  logic [63:0]   rd_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [CW-1:0] cnt_r [4];
  logic [2:0]    state_r, state_nxt;
  lfc_req_t      req_r;
  logic          pass_r, pass_nxt;     // second flow pass scans b
  logic [CW-1:0] oi_r, oi_nxt;         // outer index
  logic [CW-1:0] ii_r, ii_nxt;         // inner index, one past address
  logic [1:0]    sk_r, sk_nxt;         // search set position 0..2
  logic [63:0]   cur_r;                // item being searched for
  logic          hit_r, hit_nxt;
  logic          vld_r;                // inner read data valid
  logic [1:0]    st_r, st_nxt;
  logic          busy_r, busy_nxt;
  logic [1:0]    oset, sset;
  logic [1:0]    nsk;
  logic          last_sk, add_mode;

  assign add_mode = (req_r.req_type == REQ_ADD);
  // Outer set and the sets searched for each mode.
  always_comb begin
    oset = pass_r ? SET_B : SET_A;
    case (sk_r)
      2'd0:    sset = add_mode ? req_r.set_select : (pass_r ? SET_A : SET_B);
      2'd1:    sset = SET_P1;
      default: sset = SET_P2;
    endcase
    nsk = (req_r.req_type == REQ_SUBSET) ? 2'd2 : (add_mode ? 2'd1 : 2'd3);
    last_sk = (sk_r + 2'd1 == nsk);
  end

  // Memory read address: outer fetch or inner scan.
  always_comb begin
    if (state_r == S_OUTER) rd_addr = {oset, oi_r[IW-1:0]};
    else                    rd_addr = {sset, ii_r[IW-1:0]};
  end
  // The new category is written once the last stored entry has been compared.
  assign wr_en = (state_r == S_INNER) && add_mode && last_sk
               && (ii_r == cnt_r[sset]) && !hit_nxt
               && (cnt_r[req_r.set_select] < DEPTH_C);
  always_ff @(posedge clk) begin
    rd_r <= mem[rd_addr];
    if (wr_en) mem[{req_r.set_select, cnt_r[req_r.set_select][IW-1:0]}] <= req_r.category;
  end

  assign q_ready   = !busy_r;
  assign res_valid = (state_r == S_DONE);
  assign res_status = st_r;
  assign res_count  = 7'(cnt_r[req_r.set_select]);

  // Request sequencer.
  always_comb begin
    state_nxt = state_r; pass_nxt = pass_r; oi_nxt = oi_r; ii_nxt = ii_r;
    sk_nxt = sk_r; hit_nxt = hit_r; st_nxt = st_r; busy_nxt = busy_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          busy_nxt = 1'b1; pass_nxt = 1'b0; oi_nxt = '0; st_nxt = ST_OK;
          ii_nxt = '0; sk_nxt = 2'd0; hit_nxt = 1'b0;
          if (q_req.req_type == REQ_CLEAR) state_nxt = S_DONE;
          else if (q_req.req_type == REQ_ADD) state_nxt = S_INNER;
          else state_nxt = S_OUTER;
        end
      end
      S_OUTER: begin
        if (oi_r >= cnt_r[oset]) begin
          if (req_r.req_type == REQ_FLOW && !pass_r) begin
            pass_nxt = 1'b1; oi_nxt = '0;
          end else state_nxt = S_DONE;
        end else state_nxt = S_OWAIT;
      end
      S_OWAIT: begin
        ii_nxt = '0; sk_nxt = 2'd0; hit_nxt = 1'b0;
        if (req_r.req_type == REQ_FLOW && (rd_r[secrecy_bit] == pass_r)) begin
          oi_nxt = oi_r + CW'(1); state_nxt = S_OUTER;
        end else state_nxt = S_INNER;
      end
      S_INNER: begin
        if (vld_r && rd_r == cur_r) hit_nxt = 1'b1;
        if (hit_nxt) begin
          if (add_mode) state_nxt = S_DONE;
          else begin oi_nxt = oi_r + CW'(1); state_nxt = S_OUTER; end
        end else if (ii_r < cnt_r[sset]) ii_nxt = ii_r + CW'(1);
        else begin
          if (!last_sk) begin sk_nxt = sk_r + 2'd1; ii_nxt = '0; end
          else if (add_mode) begin
            if (cnt_r[req_r.set_select] >= DEPTH_C) st_nxt = ST_FULL;
            state_nxt = S_DONE;
          end else begin st_nxt = ST_FAIL; state_nxt = S_DONE; end
        end
      end
      S_DONE: begin
        if (res_ready) begin state_nxt = S_IDLE; busy_nxt = 1'b0; end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; busy_r <= 1'b0; vld_r <= 1'b0;
      for (int k = 0; k < 4; k++) cnt_r[k] <= '0;
    end else begin
      state_r <= state_nxt; busy_r <= busy_nxt;
      vld_r <= (state_r == S_INNER) && (ii_r < cnt_r[sset]) && !hit_nxt;
      if (state_r == S_IDLE && q_valid && q_req.req_type == REQ_CLEAR)
        cnt_r[q_req.set_select] <= '0;
      if (wr_en) cnt_r[req_r.set_select] <= cnt_r[req_r.set_select] + CW'(1);
    end
  end
  always_ff @(posedge clk) begin
    pass_r <= pass_nxt; oi_r <= oi_nxt; ii_r <= ii_nxt; sk_r <= sk_nxt;
    hit_r <= hit_nxt; st_r <= st_nxt;
    if (state_r == S_IDLE && q_valid) begin
      req_r <= q_req; cur_r <= q_req.category;
    end
    if (state_r == S_OWAIT) cur_r <= rd_r;
  end

  `include "label_flow_checker_unit_assert.svh"
  `LFC_ASSERT_IMP(a_cnt_bound, wr_en, cnt_r[req_r.set_select] < DEPTH_C)
  `LFC_ASSERT_IMP(a_busy_done, res_valid, busy_r)
  `LFC_ASSERT_NXT(a_wr_done, wr_en, state_r == S_DONE)
endmodule

FILE: rtl/core/label_flow_checker_unit.sv
// Top level of the label flow checker.
//   channel | direction | contents
//   in_     | slave     | request transaction
//   out_    | master    | result transaction
//   cfg_    | slave     | secrecy bit position write
// A request is queued by the front end and run by one sequencer on a
// set memory with one read and one write port. Synchronous active-low reset
// empties all sets at once and sets the secrecy bit to 63. A stalled result
// holds the sequencer; the two-entry queue then fills.
`timescale 1ns / 1ps
module label_flow_checker_unit #(
  parameter int LABEL_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // set_select[1:0], category[65:2], zeros
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // status[1:0], entry_count[8:2], zeros
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data
);
  import lfc_pkg::*;
  lfc_req_t   in_req, q_req;
  logic       q_valid, q_ready;
  logic [1:0] st;
  logic [6:0] cnt;
  logic [5:0] sec_r;

  // Configuration register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) sec_r <= 6'd63;
    else if (cfg_valid) sec_r <= cfg_data;
  end

  assign in_req = '{req_type: in_tuser, set_select: in_tdata[1:0], category: in_tdata[65:2]};
  assign out_tdata = {7'd0, cnt, st};

  lfc_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_req,
    .q_valid, .q_ready, .q_req
  );
  lfc_back #(.LABEL_DEPTH(LABEL_DEPTH)) u_back (
    .clk, .rst_n, .secrecy_bit(sec_r), .q_valid, .q_ready, .q_req,
    .res_valid(out_tvalid), .res_ready(out_tready), .res_status(st), .res_count(cnt)
  );
endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the label flow checker unit.
`timescale 1ns / 1ps
module tb_top;
  import lfc_pkg::*;

  localparam int DEPTH       = 64;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int PHASE_ITEMS = 64;

  typedef struct {
    logic [1:0]  status;
    logic [6:0]  count;
  } verdict_t;

  typedef struct {
    logic [1:0]  req;
    logic [1:0]  sel;
    logic [63:0] cat;
    bit          typed;
    logic [1:0]  status;
    logic [6:0]  count;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [5:0]  cfg_data = '0;

  // Shadow copy of the category sets and the secrecy bit.
  logic [63:0] shadow_cat [4][DEPTH];
  int          shadow_cnt [4];
  logic [5:0]  shadow_secrecy;

  verdict_t    verdict_q[$];
  logic [63:0] cat_pool[16];
  int          mismatches = 0;
  int          results_seen = 0;
  int          items_sent = 0;
  int          cycles = 0;
  int          burst_left = 0;
  int          hold_cnt = 0;
  bit          want_hold = 1'b0;

  always #5 clk = ~clk;

  label_flow_checker_unit #(.LABEL_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  function automatic bit holds(int s, logic [63:0] c);
    for (int i = 0; i < shadow_cnt[s]; i++)
      if (shadow_cat[s][i] == c) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit flow_permitted();
    logic [63:0] c;
    for (int i = 0; i < shadow_cnt[SET_A]; i++) begin
      c = shadow_cat[SET_A][i];
      if (c[shadow_secrecy] && !holds(SET_B, c) && !holds(SET_P1, c) && !holds(SET_P2, c))
        return 1'b0;
    end
    for (int i = 0; i < shadow_cnt[SET_B]; i++) begin
      c = shadow_cat[SET_B][i];
      if (!c[shadow_secrecy] && !holds(SET_A, c) && !holds(SET_P1, c) && !holds(SET_P2, c))
        return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit subset_holds();
    logic [63:0] c;
    for (int i = 0; i < shadow_cnt[SET_A]; i++) begin
      c = shadow_cat[SET_A][i];
      if (!holds(SET_B, c) && !holds(SET_P1, c)) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Applies one request to the shadow sets and returns the expected result.
  function automatic verdict_t apply_request(logic [1:0] req, logic [1:0] sel,
                                             logic [63:0] cat);
    verdict_t v;
    v.status = ST_OK;
    case (req)
      REQ_CLEAR: shadow_cnt[sel] = 0;
      REQ_ADD: begin
        if (!holds(sel, cat)) begin
          if (shadow_cnt[sel] >= DEPTH) v.status = ST_FULL;
          else begin
            shadow_cat[sel][shadow_cnt[sel]] = cat;
            shadow_cnt[sel]++;
          end
        end
      end
      REQ_FLOW: v.status = flow_permitted() ? ST_OK : ST_FAIL;
      default:  v.status = subset_holds() ? ST_OK : ST_FAIL;
    endcase
    v.count = shadow_cnt[sel][6:0];
    return v;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  // Sends one request transaction in bursts with random gaps between them.
  task automatic send_request(logic [1:0] req, logic [1:0] sel, logic [63:0] cat,
                              bit typed = 1'b0, logic [1:0] st = '0,
                              logic [6:0] cnt = '0);
    verdict_t v;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid    <= 1'b1;
    in_tuser     <= req;
    in_tdata     <= {6'b0, cat, sel};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    v = apply_request(req, sel, cat);
    if (typed) begin
      if (v.status != st || v.count != cnt)
        $display("NOTE: typed expectation differs from prediction");
      v.status = st;
      v.count  = cnt;
    end
    verdict_q.push_back(v);
    items_sent++;
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic drain();
    if (in_tvalid) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    burst_left = 0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_secrecy(logic [5:0] bitpos);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= bitpos;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow_secrecy = bitpos;
  endtask

  // Result monitor: compares each result transaction with the oldest expectation.
  always @(posedge clk) begin
    verdict_t v;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (verdict_q.size() == 0) report_mismatch("unexpected result", 1, 0);
      else begin
        v = verdict_q.pop_front();
        if (out_tdata[1:0] != v.status) report_mismatch("status", out_tdata[1:0], v.status);
        if (out_tdata[8:2] != v.count) report_mismatch("entry_count", out_tdata[8:2], v.count);
        if (out_tdata[15:9] != '0) report_mismatch("padding", out_tdata[15:9], 0);
      end
    end
  end

  // Receiver: random stall pattern, with one long hold-off.
  always @(posedge clk) begin
    if (want_hold) begin
      want_hold = 1'b0;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else if (cycles % 200 < 60) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    logic [1:0] req;
    logic [1:0] sel;
    logic [63:0] cat;
    int pick;
    logic [5:0] phase_bit[5];

    shadow_secrecy = 6'd63;
    foreach (shadow_cnt[i]) shadow_cnt[i] = 0;
    foreach (cat_pool[i]) cat_pool[i] = {$urandom(), $urandom()};
    cat_pool[0] = '0;
    cat_pool[1] = '1;
    cat_pool[2] = 64'h8000_0000_0000_0000;
    cat_pool[3] = 64'h0000_0000_0000_0001;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: known answers after reset and for the basic cases.
    rows = '{
      '{REQ_FLOW,   SET_A,  64'd0, 1, ST_OK,   7'd0},
      '{REQ_SUBSET, SET_B,  64'd0, 1, ST_OK,   7'd0},
      '{REQ_ADD,    SET_A,  '0,    1, ST_OK,   7'd1},
      '{REQ_ADD,    SET_A,  '1,    1, ST_OK,   7'd2},
      '{REQ_ADD,    SET_A,  '1,    1, ST_OK,   7'd2},
      '{REQ_FLOW,   SET_A,  64'd0, 1, ST_FAIL, 7'd2},
      '{REQ_ADD,    SET_B,  '1,    1, ST_OK,   7'd1},
      '{REQ_FLOW,   SET_B,  64'd0, 1, ST_OK,   7'd1},
      '{REQ_SUBSET, SET_A,  64'd0, 1, ST_FAIL, 7'd2},
      '{REQ_ADD,    SET_P1, '0,    1, ST_OK,   7'd1},
      '{REQ_SUBSET, SET_P1, 64'd0, 1, ST_OK,   7'd1},
      '{REQ_ADD,    SET_B,  64'h1, 0, ST_OK,   7'd0},
      '{REQ_FLOW,   SET_P2, 64'd0, 0, ST_OK,   7'd0},
      '{REQ_ADD,    SET_P2, 64'h1, 0, ST_OK,   7'd0},
      '{REQ_FLOW,   SET_P2, '1,    0, ST_OK,   7'd0},
      '{REQ_CLEAR,  SET_A,  '1,    1, ST_OK,   7'd0},
      '{REQ_CLEAR,  SET_B,  64'd0, 1, ST_OK,   7'd0},
      '{REQ_CLEAR,  SET_P1, 64'd0, 1, ST_OK,   7'd0},
      '{REQ_CLEAR,  SET_P2, 64'd0, 1, ST_OK,   7'd0}
    };
    foreach (rows[i])
      send_request(rows[i].req, rows[i].sel, rows[i].cat, rows[i].typed,
                   rows[i].status, rows[i].count);

    // Fill one set to the brim, then a full add and a duplicate add on the full set.
    for (int i = 0; i < DEPTH; i++) send_request(REQ_ADD, SET_P2, {$urandom(), 26'd0, 6'(i)});
    send_request(REQ_ADD, SET_P2, cat_pool[1], 1, ST_FULL, 7'd64);
    send_request(REQ_ADD, SET_P2, shadow_cat[SET_P2][5], 1, ST_OK, 7'd64);
    send_request(REQ_FLOW, SET_P2, '0);
    send_request(REQ_CLEAR, SET_P2, '0, 1, ST_OK, 7'd0);

    // Random phases, each run after writing its secrecy bit position.
    phase_bit[0] = 6'd0;
    phase_bit[1] = 6'd63;
    phase_bit[2] = 6'($urandom_range(1, 62));
    phase_bit[3] = 6'($urandom());
    phase_bit[4] = 6'd63;
    for (int ph = 0; ph < 5; ph++) begin
      write_secrecy(phase_bit[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == 10) want_hold = 1'b1;
        pick = $urandom_range(0, 99);
        sel  = 2'($urandom());
        cat  = ($urandom_range(0, 4) == 0) ? {$urandom(), $urandom()}
                                           : cat_pool[$urandom_range(0, 15)];
        if (pick < 55) req = REQ_ADD;
        else if (pick < 65) req = REQ_CLEAR;
        else if (pick < 82) req = REQ_FLOW;
        else req = REQ_SUBSET;
        // Keep sets small so that checks stay short.
        if (req == REQ_ADD && shadow_cnt[sel] >= 12) req = REQ_CLEAR;
        send_request(req, sel, cat);
      end
    end

    drain();
    repeat (200) @(posedge clk);
    $display("Run covered %0d requests and %0d results over five secrecy bit settings,",
             items_sent, results_seen);
    $display("including a full set, duplicate adds and a long output stall.");
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
